>>> rtl/core/mme_pkg.sv
// Shared constants, codes and types of the matrix multiply engine.
package mme_pkg;

    localparam int ELEM_W   = 32;
    localparam int REQ_W    = 2;
    localparam int POS_W    = 3;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_NONE    = 2'd3
    } req_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A     = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_COLS_B     = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_code_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic rd_vld;
        logic clear;
    } mac_ctl_t;

endpackage

>>> rtl/core/mme_if.sv
// Handshake channel interfaces of the matrix multiply engine.
interface mme_req_if;
    import mme_pkg::*;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  row_index;
    logic [POS_W-1:0]  col_index;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, req_type, row_index, col_index, element_value, input ready);
    modport sink   (input valid, req_type, row_index, col_index, element_value, output ready);
endinterface

interface mme_rsp_if;
    import mme_pkg::*;
    logic              valid;
    logic              ready;
    logic signed [ELEM_W-1:0] product_value;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              last;

    modport source (output valid, product_value, out_row, out_col, last, input ready);
    modport sink   (input valid, product_value, out_row, out_col, last, output ready);
endinterface

interface mme_cfg_if;
    import mme_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mme_mac.sv
// Shared multiply-accumulate unit with the final shift and saturation.
module mme_mac #(
    parameter int STORE_W = 32,
    parameter int ACC_W   = 68,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mme_pkg::mac_ctl_t          ctl,
    input  logic [STORE_W-1:0]         a_data,
    input  logic [STORE_W-1:0]         b_data,
    output logic                       busy,
    output logic [mme_pkg::ELEM_W-1:0] sat_value
);
    import mme_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(33'sh1_8000_0000);

    logic signed [STORE_W-1:0]   a_s;
    logic signed [STORE_W-1:0]   b_s;
    logic signed [2*STORE_W-1:0] prod_reg;
    logic signed [2*STORE_W-1:0] prod_next;
    logic                        mul_vld_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     shifted;

    assign a_s = a_data;
    assign b_s = b_data;
    assign prod_next = a_s * b_s;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (mul_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= ctl.rd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_vld)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // Arithmetic shift rounds toward minus infinity before clamping.
    assign shifted = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sat_value = 32'h7FFF_FFFF;
        end
        else if (shifted < SAT_LO)
        begin
            sat_value = 32'h8000_0000;
        end
        else
        begin
            sat_value = shifted[ELEM_W-1:0];
        end
    end

    assign busy = mul_vld_reg;

endmodule

>>> rtl/core/matrix_multiply_engine_core.sv
// Top level of the matrix multiply engine: sequencer, operand stores and output register.
// Load items do not leave the idle state, so the engine stays ready for more items.
// For a compute item one multiplier serves every product, fed one A/B pair per cycle from the two store
// ports while an entry's reads are issued; no new item is taken until the last entry has gone out.
// Reset clears the sequencer and output valid and sets all three sizes to 8; the stores are not cleared.
module matrix_multiply_engine_core #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mme_req_if.sink   req,
    mme_rsp_if.source rsp,
    mme_cfg_if.sink   cfg
);
    import mme_pkg::*;

    localparam int STORE_W = (ELEMENT_WIDTH < ELEM_W) ? ELEMENT_WIDTH : ELEM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int ACC_W   = 2 * STORE_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        if (r == '0)
        begin
            return DIM_W'(1);
        end
        else if (int'(r) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(r);
    endfunction

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               rd_vld_reg;
    logic [CFG_W-1:0]   rows_reg, inner_reg, cols_reg;
    logic               out_vld_reg, out_vld_next;
    logic [ELEM_W-1:0]  out_val_reg;
    logic [POS_W-1:0]   out_row_reg, out_col_reg;
    logic               out_last_reg;

    logic [DIM_W-1:0]   nr, nk, nc;
    logic               in_fire, load_a, load_b, start;
    logic [ADDR_W-1:0]  load_addr, a_raddr, b_raddr;
    logic [STORE_W-1:0] load_data, a_rdata, b_rdata;
    logic               issue, emit_fire, last_entry, j_last, k_last;
    logic               mac_busy;
    logic [ELEM_W-1:0]  sat_value;
    mac_ctl_t           mac_ctl;

    assign nr = eff_dim(rows_reg);
    assign nk = eff_dim(inner_reg);
    assign nc = eff_dim(cols_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;

    assign load_a = in_fire && (req.req_type == REQ_LOAD_A)
                    && (int'(req.row_index) < int'(nr)) && (int'(req.col_index) < int'(nk));
    assign load_b = in_fire && (req.req_type == REQ_LOAD_B)
                    && (int'(req.row_index) < int'(nk)) && (int'(req.col_index) < int'(nc));
    assign start  = in_fire && (req.req_type == REQ_COMPUTE);

    assign load_addr = ADDR_W'(int'(req.row_index) * MAX_DIM + int'(req.col_index));
    assign load_data = STORE_W'(req.element_value);

    assign issue   = (state_reg == S_ISSUE);
    assign a_raddr = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign b_raddr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    mme_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_store_a (
        .clk   (clk),
        .we    (load_a),
        .waddr (load_addr),
        .wdata (load_data),
        .re    (issue),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mme_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_store_b (
        .clk   (clk),
        .we    (load_b),
        .waddr (load_addr),
        .wdata (load_data),
        .re    (issue),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign k_last     = (int'(k_reg) + 1 == int'(nk));
    assign j_last     = (int'(j_reg) + 1 == int'(nc));
    assign last_entry = j_last && (int'(i_reg) + 1 == int'(nr));
    assign emit_fire  = (state_reg == S_EMIT) && (!out_vld_reg || rsp.ready);

    // The accumulator is cleared at the start of a compute and after each entry goes out.
    assign mac_ctl.rd_vld = rd_vld_reg;
    assign mac_ctl.clear  = start || emit_fire;

    mme_mac #(.STORE_W(STORE_W), .ACC_W(ACC_W), .FRAC_BITS(FRAC_BITS)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .a_data    (a_rdata),
        .b_data    (b_rdata),
        .busy      (mac_busy),
        .sat_value (sat_value)
    );

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (k_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !mac_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_fire)
                begin
                    k_next = '0;
                    if (last_entry)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit_fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            rows_reg    <= CFG_DIM_RESET;
            inner_reg   <= CFG_DIM_RESET;
            cols_reg    <= CFG_DIM_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            rd_vld_reg  <= issue;
            out_vld_reg <= out_vld_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_ROWS_A:     rows_reg  <= cfg.data;
                    CFG_INNER_SIZE: inner_reg <= cfg.data;
                    CFG_COLS_B:     cols_reg  <= cfg.data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_val_reg  <= sat_value;
            out_row_reg  <= POS_W'(i_reg);
            out_col_reg  <= POS_W'(j_reg);
            out_last_reg <= last_entry;
        end
    end

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_vld_reg;
    assign rsp.product_value = out_val_reg;
    assign rsp.out_row       = out_row_reg;
    assign rsp.out_col       = out_col_reg;
    assign rsp.last          = out_last_reg;

    // A result word may only be formed once every product of the entry has been summed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (!rd_vld_reg && !mac_busy))
        else $error("result formed while products are still in flight");

    // The final word of a product returns the engine to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && last_entry) |=> (state_reg == S_IDLE))
        else $error("engine did not return to idle after the final word");

    // The inner index never runs past the summation length while reads are issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> (int'(k_reg) < int'(nk)))
        else $error("inner index out of range");

endmodule

>>> tb/mme_product_checker.sv
// Watches the engine channels, predicts every product entry and compares the results.
`timescale 1ns / 100ps

module mme_product_checker #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    mme_req_if   req,
    mme_rsp_if   rsp,
    mme_cfg_if   cfg,
    output int   mismatch_count,
    output int   pending_results
);
    import mme_pkg::*;

    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     last;
    } product_entry_t;

    product_entry_t           expected_products[$];
    product_entry_t           got;
    product_entry_t           want;
    logic signed [ELEM_W-1:0] a_store [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_store [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         inner_reg;
    logic [CFG_W-1:0]         cols_reg;

    function automatic int dim_used(input logic [CFG_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_DIM)
            return MAX_DIM;
        return int'(r);
    endfunction

    // Full-width sum, arithmetic shift (rounds toward minus infinity), then saturation.
    function automatic logic signed [ELEM_W-1:0] entry_of(input int i, input int j, input int nk);
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        logic signed [63:0]  av;
        logic signed [63:0]  bv;
        int                  k;
        acc = '0;
        for (k = 0; k < nk; k++)
        begin
            av  = a_store[i*MAX_DIM + k];
            bv  = b_store[k*MAX_DIM + j];
            acc = acc + (av * bv);
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > Q_MAX)
            return 32'sh7FFFFFFF;
        if (shifted < Q_MIN)
            return 32'sh80000000;
        return shifted[ELEM_W-1:0];
    endfunction

    task automatic predict_products();
        int             nr;
        int             nk;
        int             nc;
        int             i;
        int             j;
        product_entry_t e;
        nr = dim_used(rows_reg);
        nk = dim_used(inner_reg);
        nc = dim_used(cols_reg);
        for (i = 0; i < nr; i++)
        begin
            for (j = 0; j < nc; j++)
            begin
                e.value = entry_of(i, j, nk);
                e.row   = POS_W'(i);
                e.col   = POS_W'(j);
                e.last  = (i == nr - 1) && (j == nc - 1);
                expected_products.push_back(e);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  = CFG_DIM_RESET;
            inner_reg = CFG_DIM_RESET;
            cols_reg  = CFG_DIM_RESET;
            expected_products.delete();
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ROWS_A:     rows_reg  = cfg.data;
                    CFG_INNER_SIZE: inner_reg = cfg.data;
                    CFG_COLS_B:     cols_reg  = cfg.data;
                    default:        ;
                endcase
            end

            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    REQ_LOAD_A:
                        if (int'(req.row_index) < dim_used(rows_reg)
                            && int'(req.col_index) < dim_used(inner_reg))
                            a_store[int'(req.row_index)*MAX_DIM + int'(req.col_index)]
                                = req.element_value;
                    REQ_LOAD_B:
                        if (int'(req.row_index) < dim_used(inner_reg)
                            && int'(req.col_index) < dim_used(cols_reg))
                            b_store[int'(req.row_index)*MAX_DIM + int'(req.col_index)]
                                = req.element_value;
                    REQ_COMPUTE:
                        predict_products();
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                got.value = rsp.product_value;
                got.row   = rsp.out_row;
                got.col   = rsp.out_col;
                got.last  = rsp.last;
                if (expected_products.size() == 0)
                    report_mismatch($sformatf("unexpected word value %h row %0d col %0d",
                                              got.value, got.row, got.col));
                else
                begin
                    want = expected_products.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("entry (%0d,%0d) value %h, expected %h",
                                                  want.row, want.col, got.value, want.value));
                    if (got.row !== want.row)
                        report_mismatch($sformatf("entry (%0d,%0d) row %0d",
                                                  want.row, want.col, got.row));
                    if (got.col !== want.col)
                        report_mismatch($sformatf("entry (%0d,%0d) col %0d",
                                                  want.row, want.col, got.col));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("entry (%0d,%0d) last %b, expected %b",
                                                  want.row, want.col, got.last, want.last));
                end
            end

            pending_results = expected_products.size();
        end
    end

endmodule

>>> tb/matrix_multiply_engine_core_tb.sv
// Stimulus, receiver pacing, watchdog and verdict for the matrix multiply engine.
`timescale 1ns / 100ps

module matrix_multiply_engine_core_tb;
    import mme_pkg::*;

    localparam int DIM_MAX        = 8;
    localparam int WORK_ITEMS     = 500;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mme_req_if req_ch ();
    mme_rsp_if rsp_ch ();
    mme_cfg_if cfg_ch ();

    int mismatch_count;
    int pending_results;

    matrix_multiply_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    mme_product_checker #(
        .MAX_DIM   (DIM_MAX),
        .FRAC_BITS (16)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg             (cfg_ch),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #1 clk = ~clk;

    // Sizes as last written, and which store entries hold a loaded element.
    logic [CFG_W-1:0] cur_rows  = CFG_DIM_RESET;
    logic [CFG_W-1:0] cur_inner = CFG_DIM_RESET;
    logic [CFG_W-1:0] cur_cols  = CFG_DIM_RESET;
    bit               a_written [DIM_MAX*DIM_MAX];
    bit               b_written [DIM_MAX*DIM_MAX];
    int               burst_left = 0;
    int               work_items = 0;
    bit               hold_off_req = 1'b0;
    bit               hold_done = 1'b0;

    function automatic int dim_of(input logic [CFG_W-1:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > DIM_MAX)
            return DIM_MAX;
        return int'(r);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(9, 15));
            2:       return CFG_W'(1);
            3:       return CFG_W'(8);
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_value();
        logic [ELEM_W-1:0] raw;
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            3, 4:
            begin
                // Roughly -8.0 to +8.0 in Q16.16.
                raw = $urandom_range(0, 32'h000FFFFF);
                return $signed(raw - 32'h00080000);
            end
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_item(input req_code_t kind, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c, input logic signed [ELEM_W-1:0] v);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.row_index     <= r;
        req_ch.col_index     <= c;
        req_ch.element_value <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (kind)
            REQ_LOAD_A:
                if (int'(r) < dim_of(cur_rows) && int'(c) < dim_of(cur_inner))
                begin
                    a_written[int'(r)*DIM_MAX + int'(c)] = 1'b1;
                    work_items++;
                end
            REQ_LOAD_B:
                if (int'(r) < dim_of(cur_inner) && int'(c) < dim_of(cur_cols))
                begin
                    b_written[int'(r)*DIM_MAX + int'(c)] = 1'b1;
                    work_items++;
                end
            REQ_COMPUTE:
                work_items++;
            default: ;
        endcase
    endtask

    task automatic send_compute();
        send_item(REQ_COMPUTE, POS_W'($urandom), POS_W'($urandom), $signed($urandom));
    endtask

    // Waits until every expected word has come back and the engine has gone quiet.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_code_t idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_ROWS_A:     cur_rows  = val;
            CFG_INNER_SIZE: cur_inner = val;
            CFG_COLS_B:     cur_cols  = val;
            default:        ;
        endcase
    endtask

    // Loads every element the next compute will read that has never been loaded.
    task automatic fill_needed();
        int i;
        int k;
        for (i = 0; i < dim_of(cur_rows); i++)
            for (k = 0; k < dim_of(cur_inner); k++)
                if (!a_written[i*DIM_MAX + k])
                    send_item(REQ_LOAD_A, POS_W'(i), POS_W'(k), pick_value());
        for (k = 0; k < dim_of(cur_inner); k++)
            for (i = 0; i < dim_of(cur_cols); i++)
                if (!b_written[k*DIM_MAX + i])
                    send_item(REQ_LOAD_B, POS_W'(k), POS_W'(i), pick_value());
    endtask

    task automatic random_phase();
        int        n;
        int        sel;
        req_code_t noise_kind;
        write_reg(CFG_ROWS_A, pick_dim());
        write_reg(CFG_INNER_SIZE, pick_dim());
        write_reg(CFG_COLS_B, pick_dim());
        fill_needed();
        n = $urandom_range(6, 30);
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 38)
                send_item(REQ_LOAD_A, POS_W'($urandom_range(0, dim_of(cur_rows) - 1)),
                          POS_W'($urandom_range(0, dim_of(cur_inner) - 1)), pick_value());
            else if (sel < 76)
                send_item(REQ_LOAD_B, POS_W'($urandom_range(0, dim_of(cur_inner) - 1)),
                          POS_W'($urandom_range(0, dim_of(cur_cols) - 1)), pick_value());
            else if (sel < 88)
            begin
                send_compute();
                // One long receiver hold-off while a large product is in flight.
                if (!hold_done && dim_of(cur_rows) * dim_of(cur_cols) >= 16)
                begin
                    hold_off_req = 1'b1;
                    hold_done    = 1'b1;
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       noise_kind = REQ_LOAD_A;
                    1:       noise_kind = REQ_LOAD_B;
                    default: noise_kind = REQ_NONE;
                endcase
                send_item(noise_kind, POS_W'($urandom), POS_W'($urandom), $signed($urandom));
            end
        end
        send_compute();
    endtask

    // Receiver pacing: chunks of random modes, plus the requested long hold-off.
    initial
    begin : rsp_pacing
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 4);
                    mode_left = (mode == 3) ? $urandom_range(1, 25) : $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    3:       rsp_ch.ready <= 1'b0;
                    default: rsp_ch.ready <= (mode_left % 3 != 0);
                endcase
            end
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_NONE;
        req_ch.row_index     <= '0;
        req_ch.col_index     <= '0;
        req_ch.element_value <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_ROWS_A;
        cfg_ch.data          <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 2x2 operands at the value extremes, saturation both ways.
        write_reg(CFG_ROWS_A, CFG_W'(2));
        write_reg(CFG_INNER_SIZE, CFG_W'(2));
        write_reg(CFG_COLS_B, CFG_W'(2));
        write_reg(CFG_UNUSED, CFG_W'(5));
        send_item(REQ_LOAD_A, 3'd0, 3'd0, 32'sh7FFFFFFF);
        send_item(REQ_LOAD_A, 3'd0, 3'd1, 32'sh7FFFFFFF);
        send_item(REQ_LOAD_A, 3'd1, 3'd0, 32'sh80000000);
        send_item(REQ_LOAD_A, 3'd1, 3'd1, 32'sh00010000);
        send_item(REQ_LOAD_B, 3'd0, 3'd0, 32'sh7FFFFFFF);
        send_item(REQ_LOAD_B, 3'd0, 3'd1, 32'shFFFFFFFF);
        send_item(REQ_LOAD_B, 3'd1, 3'd0, 32'sh7FFFFFFF);
        send_item(REQ_LOAD_B, 3'd1, 3'd1, 32'sh00018000);
        // Loads outside the current sizes and an unknown request are dropped.
        send_item(REQ_LOAD_A, 3'd0, 3'd2, 32'sh12345678);
        send_item(REQ_LOAD_B, 3'd2, 3'd1, 32'sh55AA55AA);
        send_item(REQ_NONE, 3'd7, 3'd7, 32'shDEADBEEF);
        send_compute();

        // Zero sizes act as one; tiny negative product rounds toward minus infinity.
        write_reg(CFG_ROWS_A, '0);
        write_reg(CFG_INNER_SIZE, '0);
        write_reg(CFG_COLS_B, '0);
        send_item(REQ_LOAD_A, 3'd0, 3'd0, 32'shFFFFFFFF);
        send_item(REQ_LOAD_B, 3'd0, 3'd0, 32'sh00000001);
        send_compute();
        send_item(REQ_LOAD_A, 3'd0, 3'd0, 32'sh80000000);
        send_item(REQ_LOAD_B, 3'd0, 3'd0, 32'sh80000000);
        send_compute();
        send_item(REQ_LOAD_B, 3'd0, 3'd0, 32'sh7FFFFFFF);
        send_compute();

        // Oversized registers are clamped to the largest matrix.
        write_reg(CFG_ROWS_A, CFG_W'(15));
        write_reg(CFG_INNER_SIZE, CFG_W'(15));
        write_reg(CFG_COLS_B, CFG_W'(15));
        fill_needed();
        send_compute();

        work_items = 0;
        while (work_items < WORK_ITEMS)
            random_phase();

        wait_drained();
        if (mismatch_count == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
